>>> src/q6k_pkg.sv
// Shared types and constants for the Q6_K super-block dequantizer.
// Used by every module of the block; depends on nothing else.
package q6k_pkg;

    localparam int Q6K_QDEPTH = 4;

    localparam logic [7:0]  HIGH_BASE  = 8'd128;
    localparam logic [7:0]  SCALE_BASE = 8'd192;
    localparam logic [7:0]  D_LO_OFS   = 8'd208;
    localparam logic [7:0]  D_HI_OFS   = 8'd209;
    localparam logic [5:0]  Q_BIAS     = 6'd32;
    localparam logic [31:0] CANON_NAN  = 32'h7FC0_0000;
    localparam logic [4:0]  HALF_EXP_MAX = 5'h1F;
    localparam logic [7:0]  SUBN_EBASE = 8'd103;
    localparam logic [7:0]  NORM_EBIAS = 8'd102;

    typedef struct packed {
        logic       req_type;
        logic [7:0] byte_offset;
        logic [7:0] byte_value;
        logic [7:0] weight_index;
    } t_in_item;

    typedef struct packed {
        logic [31:0] weight_bits;
        logic [7:0]  weight_position;
    } t_out_item;

    typedef enum logic [2:0] {
        CLS_LOW,
        CLS_HIGH,
        CLS_SCALE,
        CLS_D_LO,
        CLS_D_HI,
        CLS_READ
    } t_cls;

    // addr is the byte offset for loads and the weight index for reads
    typedef struct packed {
        t_cls       cls;
        logic [7:0] addr;
        logic [7:0] data;
    } t_qent;

    typedef struct packed {
        logic  push;
        t_qent ent;
    } t_q_wr;

    typedef struct packed {
        logic  empty;
        t_qent ent;
    } t_q_rd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_MUL1,
        S_MUL2,
        S_NORM1,
        S_NORM2,
        S_OUT
    } t_state;

endpackage

>>> src/q6k_front.sv
// Front stage: accepts transactions, classifies them by target and drops stray loads.
// Depends on q6k_pkg; feeds q6k_queue.
module q6k_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  q6k_pkg::t_in_item i_in_item,
    input  logic              i_q_full,
    output q6k_pkg::t_q_wr    o_q_wr
);

    logic          r_valid;
    logic          n_valid;
    q6k_pkg::t_qent r_ent;
    q6k_pkg::t_qent n_ent;
    logic          w_keep;
    logic          w_accept;
    logic          w_push_q;

    assign full     = r_valid && i_q_full;
    assign w_accept = push && !full;
    assign w_push_q = r_valid && !i_q_full;

    always_comb begin
        w_keep     = 1'b1;
        n_ent.addr = i_in_item.byte_offset;
        n_ent.data = i_in_item.byte_value;
        if (i_in_item.req_type) begin
            n_ent.cls  = q6k_pkg::CLS_READ;
            n_ent.addr = i_in_item.weight_index;
        end else if (i_in_item.byte_offset < q6k_pkg::HIGH_BASE) begin
            n_ent.cls = q6k_pkg::CLS_LOW;
        end else if (i_in_item.byte_offset < q6k_pkg::SCALE_BASE) begin
            n_ent.cls = q6k_pkg::CLS_HIGH;
        end else if (i_in_item.byte_offset < q6k_pkg::D_LO_OFS) begin
            n_ent.cls = q6k_pkg::CLS_SCALE;
        end else if (i_in_item.byte_offset == q6k_pkg::D_LO_OFS) begin
            n_ent.cls = q6k_pkg::CLS_D_LO;
        end else if (i_in_item.byte_offset == q6k_pkg::D_HI_OFS) begin
            n_ent.cls = q6k_pkg::CLS_D_HI;
        end else begin
            // beyond the super-block: drop
            n_ent.cls = q6k_pkg::CLS_LOW;
            w_keep    = 1'b0;
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (w_push_q) begin
            n_valid = 1'b0;
        end
        if (w_accept && w_keep) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_keep) begin
            r_ent <= n_ent;
        end
    end

    assign o_q_wr.push = w_push_q;
    assign o_q_wr.ent  = r_ent;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_q_full) |=> (r_valid && $stable(r_ent)))
        else $error("front entry lost while queue full");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_keep && !r_valid) |=> !r_valid)
        else $error("dropped load reached the queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_wr.push |-> r_valid)
        else $error("queue push without a held entry");

endmodule

>>> src/q6k_queue.sv
// Short FIFO between the front stage and the execution back end.
// Depends on q6k_pkg.
module q6k_queue #(
    parameter int DEPTH = q6k_pkg::Q6K_QDEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  q6k_pkg::t_q_wr i_q_wr,
    output logic           o_full,
    input  logic           i_pop,
    output q6k_pkg::t_q_rd o_q_rd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    q6k_pkg::t_qent r_mem [DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic [PW-1:0]  n_wp;
    logic [PW-1:0]  n_rp;
    logic [CW-1:0]  n_cnt;
    logic           w_wr;
    logic           w_rd;

    assign o_full = (r_cnt == CW'(DEPTH));
    assign w_wr   = i_q_wr.push && !o_full;
    assign w_rd   = i_pop && (r_cnt != '0);

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_wr) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (w_rd) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_q_wr.ent;
        end
    end

    assign o_q_rd.empty = (r_cnt == '0);
    assign o_q_rd.ent   = r_mem[r_rp];

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && !w_rd) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count missed a push");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wp == r_rp))
        else $error("empty queue with pointers apart");

endmodule

>>> src/q6k_back.sv
// Back end: holds the super-block bytes, applies loads and dequantizes reads to fp32.
// Depends on q6k_pkg; takes entries from q6k_queue.
module q6k_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  q6k_pkg::t_q_rd     i_q_rd,
    output logic               o_q_pop,
    input  logic               pop,
    output logic               empty,
    output q6k_pkg::t_out_item o_out_item
);

    // byte stores
    logic [7:0] r_low_mem  [128];
    logic [7:0] r_high_mem [64];
    logic [7:0] r_scales   [16];
    logic [7:0] r_d_lo;
    logic [7:0] r_d_hi;
    logic [7:0] r_nib_rd;
    logic [7:0] r_pair_rd;

    q6k_pkg::t_state r_state;
    q6k_pkg::t_state n_state;

    logic w_low_we, w_high_we, w_scale_we, w_dlo_we, w_dhi_we, w_rd_en;
    logic w_out_load, w_out_free;

    // datapath
    logic [7:0]  r_widx;
    logic [10:0] r_m;
    logic [7:0]  r_s_abs;
    logic [5:0]  r_q_abs;
    logic        r_sign;
    logic [7:0]  r_ebase;
    logic        r_nan;
    logic        r_inf;
    logic [23:0] r_p;
    logic [4:0]  r_lz;
    logic [31:0] r_res;
    logic        r_out_valid;
    q6k_pkg::t_out_item r_out;

    logic [10:0] n_m;
    logic [7:0]  n_s_abs;
    logic [5:0]  n_q_abs;
    logic        n_sign;
    logic [7:0]  n_ebase;
    logic        n_nan;
    logic        n_inf;
    logic [23:0] n_p;
    logic [4:0]  n_lz;
    logic [31:0] n_res;

    logic [3:0]  w_nib;
    logic [1:0]  w_pair;
    logic [5:0]  w_q6;
    logic [7:0]  w_sraw;
    logic [15:0] w_h;
    logic [4:0]  w_ex;
    logic [9:0]  w_man;
    logic        w_d_nan;
    logic        w_d_inf;
    logic [18:0] w_p1;
    logic [24:0] w_p2;
    logic [23:0] w_t1;
    logic [23:0] w_t2;
    logic [4:0]  w_l1;
    logic [4:0]  w_l2;
    logic [7:0]  w_exp;

    // ---------------- control ----------------
    assign w_out_free = !r_out_valid || pop;

    always_comb begin
        n_state = r_state;
        case (r_state)
            q6k_pkg::S_IDLE: begin
                if (!i_q_rd.empty && i_q_rd.ent.cls == q6k_pkg::CLS_READ) begin
                    n_state = q6k_pkg::S_FETCH;
                end
            end
            q6k_pkg::S_FETCH: n_state = q6k_pkg::S_MUL1;
            q6k_pkg::S_MUL1:  n_state = q6k_pkg::S_MUL2;
            q6k_pkg::S_MUL2:  n_state = q6k_pkg::S_NORM1;
            q6k_pkg::S_NORM1: n_state = q6k_pkg::S_NORM2;
            q6k_pkg::S_NORM2: n_state = q6k_pkg::S_OUT;
            q6k_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = q6k_pkg::S_IDLE;
                end
            end
            default: n_state = q6k_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop    = (r_state == q6k_pkg::S_IDLE) && !i_q_rd.empty;
        w_low_we   = o_q_pop && (i_q_rd.ent.cls == q6k_pkg::CLS_LOW);
        w_high_we  = o_q_pop && (i_q_rd.ent.cls == q6k_pkg::CLS_HIGH);
        w_scale_we = o_q_pop && (i_q_rd.ent.cls == q6k_pkg::CLS_SCALE);
        w_dlo_we   = o_q_pop && (i_q_rd.ent.cls == q6k_pkg::CLS_D_LO);
        w_dhi_we   = o_q_pop && (i_q_rd.ent.cls == q6k_pkg::CLS_D_HI);
        w_rd_en    = o_q_pop && (i_q_rd.ent.cls == q6k_pkg::CLS_READ);
        w_out_load = (r_state == q6k_pkg::S_OUT) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= q6k_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- stores ----------------
    always_ff @(posedge i_clk) begin
        if (w_low_we) begin
            r_low_mem[i_q_rd.ent.addr[6:0]] <= i_q_rd.ent.data;
        end
        if (w_rd_en) begin
            // nibble byte: half, odd quarter, lane
            r_nib_rd <= r_low_mem[{i_q_rd.ent.addr[7], i_q_rd.ent.addr[5],
                                   i_q_rd.ent.addr[4:0]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_high_we) begin
            r_high_mem[i_q_rd.ent.addr[5:0]] <= i_q_rd.ent.data;
        end
        if (w_rd_en) begin
            r_pair_rd <= r_high_mem[{i_q_rd.ent.addr[7], i_q_rd.ent.addr[4:0]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_scale_we) begin
            r_scales[i_q_rd.ent.addr[3:0]] <= i_q_rd.ent.data;
        end
        if (w_dlo_we) begin
            r_d_lo <= i_q_rd.ent.data;
        end
        if (w_dhi_we) begin
            r_d_hi <= i_q_rd.ent.data;
        end
        if (w_rd_en) begin
            r_widx <= i_q_rd.ent.addr;
        end
    end

    // ---------------- arithmetic ----------------
    always_comb begin
        w_nib = r_widx[6] ? r_nib_rd[7:4] : r_nib_rd[3:0];
        case (r_widx[6:5])
            2'd0:    w_pair = r_pair_rd[1:0];
            2'd1:    w_pair = r_pair_rd[3:2];
            2'd2:    w_pair = r_pair_rd[5:4];
            default: w_pair = r_pair_rd[7:6];
        endcase
        w_q6   = {w_pair, w_nib};
        w_sraw = r_scales[r_widx[7:4]];
        w_h    = {r_d_hi, r_d_lo};
        w_ex   = w_h[14:10];
        w_man  = w_h[9:0];
        w_d_nan = (w_ex == q6k_pkg::HALF_EXP_MAX) && (w_man != '0);
        w_d_inf = (w_ex == q6k_pkg::HALF_EXP_MAX) && (w_man == '0);

        n_m     = {(w_ex != '0), w_man};
        n_ebase = (w_ex == '0) ? q6k_pkg::SUBN_EBASE : ({3'b0, w_ex} + q6k_pkg::NORM_EBIAS);
        n_s_abs = w_sraw[7] ? (8'd0 - w_sraw) : w_sraw;
        n_q_abs = w_q6[5] ? {1'b0, w_q6[4:0]} : (q6k_pkg::Q_BIAS - w_q6);
        n_sign  = w_h[15] ^ w_sraw[7] ^ !w_q6[5];
        n_nan   = w_d_nan || (w_d_inf && ((w_sraw == '0) || (w_q6 == q6k_pkg::Q_BIAS)));
        n_inf   = w_d_inf;

        // both products are exact: at most 23 significant bits
        w_p1 = {8'b0, r_m} * {11'b0, r_s_abs};
        w_p2 = {6'b0, r_p[18:0]} * {19'b0, r_q_abs};

        // normalise in two steps: 16/8 then 4/2/1
        w_t1 = r_p;
        w_l1 = r_lz;
        if (w_t1[23:8] == '0) begin
            w_t1 = {w_t1[7:0], 16'b0};
            w_l1 = w_l1 + 5'd16;
        end
        if (w_t1[23:16] == '0) begin
            w_t1 = {w_t1[15:0], 8'b0};
            w_l1 = w_l1 + 5'd8;
        end
        w_t2 = r_p;
        w_l2 = r_lz;
        if (w_t2[23:20] == '0) begin
            w_t2 = {w_t2[19:0], 4'b0};
            w_l2 = w_l2 + 5'd4;
        end
        if (w_t2[23:22] == '0) begin
            w_t2 = {w_t2[21:0], 2'b0};
            w_l2 = w_l2 + 5'd2;
        end
        if (!w_t2[23]) begin
            w_t2 = {w_t2[22:0], 1'b0};
            w_l2 = w_l2 + 5'd1;
        end
        w_exp = r_ebase + 8'd23 - {3'b0, w_l2};

        n_p   = r_p;
        n_lz  = r_lz;
        n_res = r_res;
        case (r_state)
            q6k_pkg::S_MUL1: begin
                n_p  = {5'b0, w_p1};
                n_lz = '0;
            end
            q6k_pkg::S_MUL2:  n_p = w_p2[23:0];
            q6k_pkg::S_NORM1: begin
                n_p  = w_t1;
                n_lz = w_l1;
            end
            q6k_pkg::S_NORM2: begin
                if (r_nan) begin
                    n_res = q6k_pkg::CANON_NAN;
                end else if (r_inf) begin
                    n_res = {r_sign, 8'hFF, 23'b0};
                end else if (w_t2 == '0) begin
                    n_res = {r_sign, 31'b0};
                end else begin
                    n_res = {r_sign, w_exp, w_t2[22:0]};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == q6k_pkg::S_FETCH) begin
            r_m     <= n_m;
            r_s_abs <= n_s_abs;
            r_q_abs <= n_q_abs;
            r_sign  <= n_sign;
            r_ebase <= n_ebase;
            r_nan   <= n_nan;
            r_inf   <= n_inf;
        end
        r_p   <= n_p;
        r_lz  <= n_lz;
        r_res <= n_res;
        if (w_out_load) begin
            r_out.weight_bits     <= r_res;
            r_out.weight_position <= r_widx;
        end
    end

    assign empty      = !r_out_valid;
    assign o_out_item = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == q6k_pkg::S_IDLE && n_state == q6k_pkg::S_FETCH) |-> w_rd_en)
        else $error("read started without a queued read");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_out_valid && r_state == q6k_pkg::S_IDLE))
        else $error("result hand-off lost");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.weight_bits[30:23] == 8'hFF && r_out.weight_bits[22:0] != '0)
        |-> (r_out.weight_bits == q6k_pkg::CANON_NAN))
        else $error("non-canonical NaN at output");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == q6k_pkg::S_IDLE && !i_q_rd.empty))
        else $error("queue popped while busy");

endmodule

>>> src/q6k_superblock_dequantizer_unit.sv
// Top level of the Q6_K super-block dequantizer: front stage, queue and back end.
// Depends on q6k_pkg, q6k_front, q6k_queue and q6k_back.

// Holds one 210-byte Q6_K super-block and turns any of its 256 weights into an
// fp32 bit pattern. Push a load to write one byte (offsets 210 and up are
// ignored) or a read to get one weight back with its index. The back end retires
// a load as it pops it; a read runs from the queue head to the result register
// through store read, operand fetch, two integer multiplies, two normalise steps
// (the second also packs) and hand-off, and no new transaction is taken before
// it is done. The front register and a QDEPTH-entry queue keep push open while
// the back end works, and a finished result waits in its own register while the
// next transaction is taken. The bytes behind a read must have been loaded first.
module q6k_superblock_dequantizer_unit #(
    parameter int QDEPTH = q6k_pkg::Q6K_QDEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  q6k_pkg::t_in_item  i_in_item,
    output logic               empty,
    input  logic               pop,
    output q6k_pkg::t_out_item o_out_item
);

    q6k_pkg::t_q_wr w_q_wr;
    q6k_pkg::t_q_rd w_q_rd;
    logic           w_q_full;
    logic           w_q_pop;

    q6k_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_in_item (i_in_item),
        .i_q_full  (w_q_full),
        .o_q_wr    (w_q_wr)
    );

    q6k_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_wr  (w_q_wr),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_q_rd  (w_q_rd)
    );

    q6k_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_rd     (w_q_rd),
        .o_q_pop    (w_q_pop),
        .pop        (pop),
        .empty      (empty),
        .o_out_item (o_out_item)
    );

endmodule
